// ===== rtl/core/tlc_pkg.sv =====
// Shared types, constants and functions for the two-channel lux calculator.
// Used by tlc_div_cell, tlc_seg_path and two_channel_lux_calculator.
package tlc_pkg;

    // Field widths
    localparam int CNT_W   = 16;  // sensor channel count
    localparam int RATIO_W = 17;  // ir/full ratio, Q1.16
    localparam int LUX_W   = 19;  // lux, fixed point
    localparam int COEF_W  = 20;  // segment coefficients, Q0.24
    localparam int PROD_W  = 52;  // aligned terms, Q40
    localparam int DIFF_W  = 53;  // signed difference of aligned terms
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 24;
    localparam int DIV_CELLS    = RATIO_W;  // one quotient bit per cell

    // Default parameter values
    localparam int LUX_FRAC_BITS_DEF     = 8;
    localparam int POWER_TABLE_DEPTH_DEF = 256;

    localparam logic [RATIO_W-1:0] RATIO_MAX  = 17'h1FFFF;
    localparam logic [RATIO_W-1:0] BOUND_SEG1 = 17'd32768;  // 0.50
    localparam logic [RATIO_W-1:0] BOUND_SEG2 = 17'd39977;  // 0.61
    localparam logic [RATIO_W-1:0] BOUND_SEG3 = 17'd52429;  // 0.80
    localparam logic [RATIO_W-1:0] BOUND_SEG4 = 17'd85197;  // 1.30
    localparam logic [LUX_W-1:0]   LUX_MAX    = 19'h7FFFF;

    // Coefficients, Q0.24
    localparam logic [COEF_W-1:0] K_A1 = 20'd510027;
    localparam logic [COEF_W-1:0] K_B1 = 20'd1040187;
    localparam logic [COEF_W-1:0] K_A2 = 20'd375810;
    localparam logic [COEF_W-1:0] K_B2 = 20'd520094;
    localparam logic [COEF_W-1:0] K_A3 = 20'd214748;
    localparam logic [COEF_W-1:0] K_B3 = 20'd256691;
    localparam logic [COEF_W-1:0] K_A4 = 20'd24495;
    localparam logic [COEF_W-1:0] K_B4 = 20'd18790;

    // Segment code reported with each result
    typedef enum logic [2:0] {
        SEG_NONE  = 3'd0,  // full count is zero
        SEG_ONE   = 3'd1,  // power-law segment
        SEG_TWO   = 3'd2,
        SEG_THREE = 3'd3,
        SEG_FOUR  = 3'd4,
        SEG_OVER  = 3'd5   // ratio above 1.30
    } t_seg;

    // Beat moving down the divider chain
    typedef struct packed {
        logic               valid;
        logic [CNT_W-1:0]   full;
        logic [CNT_W-1:0]   ir;
        logic [CNT_W-1:0]   rem;
        logic [RATIO_W-1:0] quo;
        logic               sat;   // quotient exceeds RATIO_MAX
    } t_div_beat;

    // Full-channel coefficient per segment (zero where no segment applies)
    function automatic logic [COEF_W-1:0] seg_ka(input t_seg seg);
        logic [COEF_W-1:0] k;
        unique case (seg)
            SEG_ONE:   k = K_A1;
            SEG_TWO:   k = K_A2;
            SEG_THREE: k = K_A3;
            SEG_FOUR:  k = K_A4;
            default:   k = '0;
        endcase
        return k;
    endfunction

    // Subtracted coefficient per segment
    function automatic logic [COEF_W-1:0] seg_kb(input t_seg seg);
        logic [COEF_W-1:0] k;
        unique case (seg)
            SEG_ONE:   k = K_B1;
            SEG_TWO:   k = K_B2;
            SEG_THREE: k = K_B3;
            SEG_FOUR:  k = K_B4;
            default:   k = '0;
        endcase
        return k;
    endfunction

    // Power table entry: largest y with y^5 * (2D)^7 <= 2^80 * idx^7,
    // i.e. floor(2^16 * (idx/(2D))^1.4). Evaluated at elaboration.
    function automatic logic [15:0] pow_entry(input int unsigned idx,
                                              input int unsigned depth);
        logic [191:0] scale;
        logic [191:0] rhs;
        logic [191:0] lhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        int           j;
        int           it;
        scale = 192'd1;
        for (j = 0; j < 7; j++) scale = scale * 192'(2 * depth);
        rhs = 192'd1;
        for (j = 0; j < 7; j++) rhs = rhs * 192'(idx);
        rhs = rhs << 80;
        lo = 0;
        hi = 65535;
        for (it = 0; it < 17; it++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 1) >> 1);
                lhs = scale;
                for (j = 0; j < 5; j++) lhs = lhs * 192'(mid);
                if (lhs <= rhs) lo = mid;
                else hi = mid - 1;
            end
        end
        return 16'(lo);
    endfunction

endpackage

// ===== rtl/core/tlc_div_cell.sv =====
// One cell of the ratio divider chain: one restoring step, one quotient bit.
// Depends on tlc_pkg (t_div_beat, widths).
module tlc_div_cell #(
    parameter bit FIRST = 1'b0   // first cell shifts in the ir count's lowest bit
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  tlc_pkg::t_div_beat i_beat,
    output tlc_pkg::t_div_beat o_beat
);

    logic [tlc_pkg::CNT_W:0]   w_trial;
    logic                      w_ge;
    logic [tlc_pkg::CNT_W-1:0] w_rem;
    logic                      r_valid;
    tlc_pkg::t_div_beat        r_beat;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        w_trial = {i_beat.rem, (FIRST ? i_beat.ir[0] : 1'b0)};
        w_ge    = w_trial >= {1'b0, i_beat.full};
        w_rem   = w_ge ? tlc_pkg::CNT_W'(w_trial - {1'b0, i_beat.full})
                       : w_trial[tlc_pkg::CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_beat.valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat.full <= i_beat.full;
            r_beat.ir   <= i_beat.ir;
            r_beat.rem  <= w_rem;
            r_beat.quo  <= {i_beat.quo[tlc_pkg::RATIO_W-2:0], w_ge};
            r_beat.sat  <= i_beat.sat;
        end
    end

    always_comb begin
        o_beat.valid = r_valid;
        o_beat.full  = r_beat.full;
        o_beat.ir    = r_beat.ir;
        o_beat.rem   = r_beat.rem;
        o_beat.quo   = r_beat.quo;
        o_beat.sat   = r_beat.sat;
    end

endmodule

// ===== rtl/core/tlc_seg_path.sv =====
// Segment pick, power-table interpolation and segment arithmetic stages.
// Depends on tlc_pkg (coefficients, bounds, pow_entry, t_seg).
module tlc_seg_path #(
    parameter int LUX_FRAC_BITS     = tlc_pkg::LUX_FRAC_BITS_DEF,
    parameter int POWER_TABLE_DEPTH = tlc_pkg::POWER_TABLE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  tlc_pkg::t_div_beat        i_beat,
    output logic                      o_valid,
    output logic [tlc_pkg::LUX_W-1:0] o_lux,
    output tlc_pkg::t_seg             o_seg
);

    localparam int KW = $clog2(POWER_TABLE_DEPTH + 1);   // table index width
    localparam int PW = 15 + KW;                         // ratio * depth
    localparam int SH = 40 - LUX_FRAC_BITS;              // Q40 down to lux
    localparam int CW = tlc_pkg::CNT_W;

    // Power table, built at elaboration
    logic [15:0] w_rom [0:POWER_TABLE_DEPTH];
    for (genvar g = 0; g <= POWER_TABLE_DEPTH; g++) begin : g_rom
        assign w_rom[g] = tlc_pkg::pow_entry(g, POWER_TABLE_DEPTH);
    end

    logic [6:0] r_vld;

    // Stage 1: ratio, segment, table position
    logic [tlc_pkg::RATIO_W-1:0] w_ratio;
    logic [PW-1:0]               w_pos;
    logic                        w_top;
    tlc_pkg::t_seg               w_seg;
    tlc_pkg::t_seg               r1_seg;
    logic [KW-1:0]               r1_k;
    logic [14:0]                 r1_f;
    logic [CW-1:0]               r1_full, r1_ir;

    always_comb begin
        w_ratio = i_beat.sat ? tlc_pkg::RATIO_MAX : i_beat.quo;
        w_top   = w_ratio[16] | w_ratio[15];   // at or past the last entry
        w_pos   = PW'(w_ratio[14:0]) * PW'(POWER_TABLE_DEPTH);
        priority if (i_beat.full == '0)             w_seg = tlc_pkg::SEG_NONE;
        else if (w_ratio <= tlc_pkg::BOUND_SEG1)    w_seg = tlc_pkg::SEG_ONE;
        else if (w_ratio <= tlc_pkg::BOUND_SEG2)    w_seg = tlc_pkg::SEG_TWO;
        else if (w_ratio <= tlc_pkg::BOUND_SEG3)    w_seg = tlc_pkg::SEG_THREE;
        else if (w_ratio <= tlc_pkg::BOUND_SEG4)    w_seg = tlc_pkg::SEG_FOUR;
        else                                        w_seg = tlc_pkg::SEG_OVER;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_seg  <= w_seg;
            r1_k    <= w_top ? KW'(POWER_TABLE_DEPTH) : w_pos[PW-1:15];
            r1_f    <= w_top ? 15'd0 : w_pos[14:0];
            r1_full <= i_beat.full;
            r1_ir   <= i_beat.ir;
        end
    end

    // Stage 2: read both neighbors from the table
    logic [KW-1:0] w_k1;
    tlc_pkg::t_seg r2_seg;
    logic [15:0]   r2_rk, r2_rk1;
    logic [14:0]   r2_f;
    logic [CW-1:0] r2_full, r2_ir;

    assign w_k1 = (r1_k == KW'(POWER_TABLE_DEPTH)) ? r1_k : r1_k + KW'(1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_seg  <= r1_seg;
            r2_rk   <= w_rom[r1_k];
            r2_rk1  <= w_rom[w_k1];
            r2_f    <= r1_f;
            r2_full <= r1_full;
            r2_ir   <= r1_ir;
        end
    end

    // Stage 3: slope times fraction
    logic [15:0]   w_diff;
    tlc_pkg::t_seg r3_seg;
    logic [15:0]   r3_rk;
    logic [30:0]   r3_prod;
    logic [CW-1:0] r3_full, r3_ir;

    assign w_diff = r2_rk1 - r2_rk;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_seg  <= r2_seg;
            r3_rk   <= r2_rk;
            r3_prod <= 31'(w_diff) * 31'(r2_f);
            r3_full <= r2_full;
            r3_ir   <= r2_ir;
        end
    end

    // Stage 4: interpolated ratio^1.4
    tlc_pkg::t_seg r4_seg;
    logic [15:0]   r4_p;
    logic [CW-1:0] r4_full, r4_ir;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_seg  <= r3_seg;
            r4_p    <= r3_rk + r3_prod[30:15];
            r4_full <= r3_full;
            r4_ir   <= r3_ir;
        end
    end

    // Stage 5: full * p and the full-channel term
    tlc_pkg::t_seg                    r5_seg;
    logic [31:0]                      r5_fp;
    logic [35:0]                      r5_ka;
    logic [tlc_pkg::COEF_W-1:0]       r5_kb;
    logic [CW-1:0]                    r5_ir;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_seg <= r4_seg;
            r5_fp  <= 32'(r4_full) * 32'(r4_p);
            r5_ka  <= 36'(tlc_pkg::seg_ka(r4_seg)) * 36'(r4_full);
            r5_kb  <= tlc_pkg::seg_kb(r4_seg);
            r5_ir  <= r4_ir;
        end
    end

    // Stage 6: subtracted term, all segments aligned to Q40
    logic [31:0]                 w_opnd;
    tlc_pkg::t_seg               r6_seg;
    logic [tlc_pkg::PROD_W-1:0]  r6_at, r6_bt;

    assign w_opnd = (r5_seg == tlc_pkg::SEG_ONE) ? r5_fp : {r5_ir, 16'h0000};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_seg <= r5_seg;
            r6_at  <= {r5_ka, 16'h0000};
            r6_bt  <= tlc_pkg::PROD_W'(r5_kb) * tlc_pkg::PROD_W'(w_opnd);
        end
    end

    // Stage 7: signed difference
    tlc_pkg::t_seg              r7_seg;
    logic [tlc_pkg::DIFF_W-1:0] r7_diff;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_seg  <= r6_seg;
            r7_diff <= {1'b0, r6_at} - {1'b0, r6_bt};
        end
    end

    // Valid bits along the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_beat.valid};
        end
    end

    // Scale, clamp negatives to zero, saturate on overflow
    logic [tlc_pkg::DIFF_W-1:0] w_shifted;
    logic                       w_pos_v;

    always_comb begin
        w_shifted = r7_diff >> SH;
        w_pos_v   = !r7_diff[tlc_pkg::DIFF_W-1] && (r7_diff != '0);
        if (!w_pos_v) begin
            o_lux = '0;
        end else if (w_shifted[tlc_pkg::DIFF_W-1:tlc_pkg::LUX_W] != '0) begin
            o_lux = tlc_pkg::LUX_MAX;
        end else begin
            o_lux = w_shifted[tlc_pkg::LUX_W-1:0];
        end
    end

    assign o_valid = r_vld[6];
    assign o_seg   = r7_seg;

endmodule

// ===== rtl/core/two_channel_lux_calculator.sv =====
// Top level of the two-channel lux calculator: divider cell chain,
// segment path and output register with skid. Depends on tlc_pkg,
// tlc_div_cell and tlc_seg_path.

// Takes one beat per clock holding a full-spectrum and an infrared count and
// returns illuminance in 1/256 lux (LUX_FRAC_BITS fraction bits) with the
// segment used in tuser. Sustained rate is one beat per cycle while the
// downstream side keeps m_axis_tready high. Input to output register spans
// 25 register stages: 17 divider cells, one quotient bit each, then 7
// arithmetic stages and the output register, the first loaded at acceptance.
// When the downstream side stalls, the pipeline freezes once the skid entry
// fills; s_axis_tready depends only on that registered skid state. The
// ratio^1.4 table is built at elaboration from POWER_TABLE_DEPTH.
module two_channel_lux_calculator #(
    parameter int LUX_FRAC_BITS     = tlc_pkg::LUX_FRAC_BITS_DEF,
    parameter int POWER_TABLE_DEPTH = tlc_pkg::POWER_TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [tlc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] full_count, [31:16] ir_count
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [tlc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [18:0] lux_fixed, zero padded
    output logic [2:0]                      m_axis_tuser    // [2:0] segment
);

    localparam int CW = tlc_pkg::CNT_W;

    logic w_en;
    tlc_pkg::t_div_beat w_chain [0:tlc_pkg::DIV_CELLS];

    // Output register and skid entry
    logic                      r_out_valid, n_out_valid;
    logic                      r_skid_valid, n_skid_valid;
    logic [tlc_pkg::LUX_W-1:0] r_out_lux, n_out_lux, r_skid_lux, n_skid_lux;
    tlc_pkg::t_seg             r_out_seg, n_out_seg, r_skid_seg, n_skid_seg;
    logic                      w_take;

    // Pipeline advances while the skid entry is free
    assign w_en          = !r_skid_valid;
    assign s_axis_tready = w_en;

    // Divider head: remainder starts at ir >> 1, overflow when ir >= 2*full
    always_comb begin
        w_chain[0].valid = s_axis_tvalid;
        w_chain[0].full  = s_axis_tdata[CW-1:0];
        w_chain[0].ir    = s_axis_tdata[2*CW-1:CW];
        w_chain[0].rem   = {1'b0, s_axis_tdata[2*CW-1:CW+1]};
        w_chain[0].quo   = '0;
        w_chain[0].sat   = {1'b0, s_axis_tdata[2*CW-1:CW]}
                           >= {s_axis_tdata[CW-1:0], 1'b0};
    end

    for (genvar c = 0; c < tlc_pkg::DIV_CELLS; c++) begin : g_div
        tlc_div_cell #(
            .FIRST (c == 0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_beat  (w_chain[c]),
            .o_beat  (w_chain[c+1])
        );
    end

    logic                      w_pipe_valid;
    logic [tlc_pkg::LUX_W-1:0] w_pipe_lux;
    tlc_pkg::t_seg             w_pipe_seg;

    tlc_seg_path #(
        .LUX_FRAC_BITS     (LUX_FRAC_BITS),
        .POWER_TABLE_DEPTH (POWER_TABLE_DEPTH)
    ) u_seg_path (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_beat  (w_chain[tlc_pkg::DIV_CELLS]),
        .o_valid (w_pipe_valid),
        .o_lux   (w_pipe_lux),
        .o_seg   (w_pipe_seg)
    );

    always_comb begin
        w_take       = r_out_valid && m_axis_tready;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_lux    = r_out_lux;
        n_out_seg    = r_out_seg;
        n_skid_lux   = r_skid_lux;
        n_skid_seg   = r_skid_seg;
        priority if (r_skid_valid) begin
            if (w_take) begin
                n_out_lux    = r_skid_lux;
                n_out_seg    = r_skid_seg;
                n_skid_valid = 1'b0;
            end
        end else if (w_pipe_valid) begin
            if (!r_out_valid || w_take) begin
                n_out_valid = 1'b1;
                n_out_lux   = w_pipe_lux;
                n_out_seg   = w_pipe_seg;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_lux   = w_pipe_lux;
                n_skid_seg   = w_pipe_seg;
            end
        end else begin
            if (w_take) n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_lux  <= n_out_lux;
        r_out_seg  <= n_out_seg;
        r_skid_lux <= n_skid_lux;
        r_skid_seg <= n_skid_seg;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = tlc_pkg::OUT_TDATA_W'(r_out_lux);
    assign m_axis_tuser  = r_out_seg;

endmodule

// ===== dv/tlc_lux_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for two_channel_lux_calculator: predicts lux and segment for each
// accepted count pair and checks the result stream in order.
// Depends on tlc_pkg for widths, bounds, coefficients and the segment enum.
module tlc_lux_checker #(
    parameter int LUX_FRAC_BITS     = tlc_pkg::LUX_FRAC_BITS_DEF,
    parameter int POWER_TABLE_DEPTH = tlc_pkg::POWER_TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_pair_valid,
    input  logic                            i_pair_ready,
    input  logic [tlc_pkg::IN_TDATA_W-1:0]  i_pair_data,   // [15:0] full_count, [31:16] ir_count
    input  logic                            i_lux_valid,
    input  logic                            i_lux_ready,
    input  logic [tlc_pkg::OUT_TDATA_W-1:0] i_lux_data,    // [18:0] lux_fixed, zero padded
    input  logic [2:0]                      i_lux_user,    // [2:0] segment
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked,
    output logic [5:0]                      o_seg_seen
);

    typedef struct {
        logic [tlc_pkg::LUX_W-1:0] lux;
        tlc_pkg::t_seg             seg;
    } t_lux_result;

    t_lux_result lux_due[$];
    logic [15:0] pow_tbl [0:POWER_TABLE_DEPTH];
    int          fails;
    int          checked;
    logic [5:0]  seen;

    // ratio^1.4 table: greedy bit search for the largest y with
    // y^5 * (2D)^7 <= 2^80 * i^7
    initial begin : build_pow_tbl
        logic [191:0] scale;
        logic [191:0] rhs;
        logic [191:0] lhs;
        logic [15:0]  y;
        logic [15:0]  trial;
        int           i;
        int           j;
        int           b;
        scale = 192'd1;
        for (j = 0; j < 7; j++) scale = scale * 192'(2 * POWER_TABLE_DEPTH);
        for (i = 0; i <= POWER_TABLE_DEPTH; i++) begin
            rhs = 192'd1;
            for (j = 0; j < 7; j++) rhs = rhs * 192'(i);
            rhs = rhs << 80;
            y = '0;
            for (b = 15; b >= 0; b--) begin
                trial = y | (16'd1 << b);
                lhs = scale;
                for (j = 0; j < 5; j++) lhs = lhs * 192'(trial);
                if (lhs <= rhs) y = trial;
            end
            pow_tbl[i] = y;
        end
    end

    // Interpolated ratio^1.4 in Q0.16 for a Q1.16 ratio
    function automatic longint power_of_ratio(
        input logic [tlc_pkg::RATIO_W-1:0] ratio
    );
        longint unsigned pos;
        longint unsigned k;
        longint unsigned f;
        longint unsigned lo_e;
        longint unsigned hi_e;
        pos = 64'(ratio) * 64'(POWER_TABLE_DEPTH);
        k   = pos >> 15;
        f   = pos & 64'h7FFF;
        if (k >= 64'(POWER_TABLE_DEPTH))
            return longint'(pow_tbl[POWER_TABLE_DEPTH]);
        lo_e = 64'(pow_tbl[k]);
        hi_e = 64'(pow_tbl[k + 1]);
        return longint'(lo_e + (((hi_e - lo_e) * f) >> 15));
    endfunction

    // Lux and segment for one count pair
    function automatic t_lux_result predict_lux(input logic [tlc_pkg::CNT_W-1:0] full,
                                                input logic [tlc_pkg::CNT_W-1:0] ir);
        t_lux_result                 res;
        logic [47:0]                 quo;
        logic [tlc_pkg::RATIO_W-1:0] ratio;
        longint                      full_l;
        longint                      ir_l;
        longint                      diff;
        longint                      scaled;
        int                          shift;
        res.lux = '0;
        res.seg = tlc_pkg::SEG_NONE;
        if (full != '0) begin
            quo    = {ir, 16'h0} / {32'h0, full};
            ratio  = (quo > 48'(tlc_pkg::RATIO_MAX)) ? tlc_pkg::RATIO_MAX
                                                      : quo[tlc_pkg::RATIO_W-1:0];
            full_l = longint'(full);
            ir_l   = longint'(ir);
            diff   = 0;
            shift  = 24 - LUX_FRAC_BITS;
            if (ratio <= tlc_pkg::BOUND_SEG1) begin
                res.seg = tlc_pkg::SEG_ONE;
                shift   = 40 - LUX_FRAC_BITS;
                diff    = ((longint'(tlc_pkg::K_A1) * full_l) << 16)
                        - longint'(tlc_pkg::K_B1) * full_l * power_of_ratio(ratio);
            end else if (ratio <= tlc_pkg::BOUND_SEG2) begin
                res.seg = tlc_pkg::SEG_TWO;
                diff    = longint'(tlc_pkg::K_A2) * full_l - longint'(tlc_pkg::K_B2) * ir_l;
            end else if (ratio <= tlc_pkg::BOUND_SEG3) begin
                res.seg = tlc_pkg::SEG_THREE;
                diff    = longint'(tlc_pkg::K_A3) * full_l - longint'(tlc_pkg::K_B3) * ir_l;
            end else if (ratio <= tlc_pkg::BOUND_SEG4) begin
                res.seg = tlc_pkg::SEG_FOUR;
                diff    = longint'(tlc_pkg::K_A4) * full_l - longint'(tlc_pkg::K_B4) * ir_l;
            end else begin
                res.seg = tlc_pkg::SEG_OVER;
            end
            // negative results clamp to zero, large ones saturate
            if (diff > 0) begin
                scaled  = diff >>> shift;
                res.lux = (scaled > longint'(tlc_pkg::LUX_MAX))
                        ? tlc_pkg::LUX_MAX : scaled[tlc_pkg::LUX_W-1:0];
            end
        end
        return res;
    endfunction

    // Queue predictions on input beats, compare on output beats
    always @(posedge i_clk) begin : score
        t_lux_result want;
        if (!i_rst_n) begin
            lux_due.delete();
            fails   = 0;
            checked = 0;
            seen    = '0;
        end else begin
            if (i_pair_valid && i_pair_ready)
                lux_due.push_back(predict_lux(i_pair_data[15:0], i_pair_data[31:16]));
            if (i_lux_valid && i_lux_ready) begin
                checked++;
                if (i_lux_user <= 3'(tlc_pkg::SEG_OVER)) seen[i_lux_user] = 1'b1;
                if (lux_due.size() == 0) begin
                    $error("unexpected result beat: lux_fixed %0d, segment %0d",
                           i_lux_data[tlc_pkg::LUX_W-1:0], i_lux_user);
                    fails++;
                end else begin
                    want = lux_due.pop_front();
                    if (i_lux_data[tlc_pkg::LUX_W-1:0] !== want.lux) begin
                        $error("lux_fixed: expected %0d, actual %0d",
                               want.lux, i_lux_data[tlc_pkg::LUX_W-1:0]);
                        fails++;
                    end
                    if (i_lux_data[tlc_pkg::OUT_TDATA_W-1:tlc_pkg::LUX_W] !== '0) begin
                        $error("tdata padding: expected 0, actual %0d",
                               i_lux_data[tlc_pkg::OUT_TDATA_W-1:tlc_pkg::LUX_W]);
                        fails++;
                    end
                    if (i_lux_user !== 3'(want.seg)) begin
                        $error("segment: expected %0d, actual %0d", want.seg, i_lux_user);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= lux_due.size();
        o_checked    <= checked;
        o_seg_seen   <= seen;
    end

endmodule

// ===== dv/two_channel_lux_calculator_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for two_channel_lux_calculator: clock, reset, count-pair
// stimulus and result back-pressure; checking lives in tlc_lux_checker.
// Depends on tlc_pkg, the block and tlc_lux_checker.
module two_channel_lux_calculator_tb;

    localparam int RANDOM_PAIRS = 1600;
    localparam int RANDOM_BLOCK = 400;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [tlc_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // [15:0] full_count, [31:16] ir_count
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [tlc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // [18:0] lux_fixed, zero padded
    logic [2:0]                      m_axis_tuser;   // [2:0] segment

    int         fail_count;
    int         pending;
    int         checked;
    logic [5:0] seg_seen;
    int         pairs_sent = 0;
    bit         quiet = 1'b0;   // no gaps on either side while set

    always #1 i_clk = ~i_clk;

    two_channel_lux_calculator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tlc_lux_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pair_valid (s_axis_tvalid),
        .i_pair_ready (s_axis_tready),
        .i_pair_data  (s_axis_tdata),
        .i_lux_valid  (m_axis_tvalid),
        .i_lux_ready  (m_axis_tready),
        .i_lux_data   (m_axis_tdata),
        .i_lux_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_seg_seen   (seg_seen)
    );

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // One input beat; returns at the falling edge after acceptance, valid still high
    task automatic send_pair(input logic [tlc_pkg::CNT_W-1:0] full,
                             input logic [tlc_pkg::CNT_W-1:0] ir);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ir, full};
        do @(posedge i_clk); while (!s_axis_tready);
        pairs_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every queued result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        @(negedge i_clk);
    endtask

    // Largest full count in 2..50000 for which some ir lands exactly on the bound
    function automatic logic [tlc_pkg::CNT_W-1:0] exact_full(
        input logic [tlc_pkg::RATIO_W-1:0] bnd
    );
        longint f;
        longint ir;
        for (f = 50000; f > 1; f--) begin
            ir = (longint'(bnd) * f + 65535) >> 16;
            if (((ir << 16) / f) == longint'(bnd)) return tlc_pkg::CNT_W'(f);
        end
        return tlc_pkg::CNT_W'(1);
    endfunction

    // Random pair: mostly aimed at a chosen segment, the rest noise
    task automatic make_random_pair(output logic [tlc_pkg::CNT_W-1:0] full,
                                    output logic [tlc_pkg::CNT_W-1:0] ir);
        int                          pick;
        tlc_pkg::t_seg               target;
        logic [tlc_pkg::RATIO_W-1:0] r_lo;
        logic [tlc_pkg::RATIO_W-1:0] r_hi;
        logic [32:0]                 prod;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            full = ($urandom_range(0, 3) == 0) ? tlc_pkg::CNT_W'($urandom_range(1, 255))
                                                : tlc_pkg::CNT_W'($urandom_range(1, 65535));
            target = tlc_pkg::t_seg'($urandom_range(1, 5));
            case (target)
                tlc_pkg::SEG_ONE: begin
                    r_lo = '0;
                    r_hi = tlc_pkg::BOUND_SEG1;
                end
                tlc_pkg::SEG_TWO: begin
                    r_lo = tlc_pkg::BOUND_SEG1 + 17'd1;
                    r_hi = tlc_pkg::BOUND_SEG2;
                end
                tlc_pkg::SEG_THREE: begin
                    r_lo = tlc_pkg::BOUND_SEG2 + 17'd1;
                    r_hi = tlc_pkg::BOUND_SEG3;
                end
                tlc_pkg::SEG_FOUR: begin
                    r_lo = tlc_pkg::BOUND_SEG3 + 17'd1;
                    r_hi = tlc_pkg::BOUND_SEG4;
                end
                default: begin
                    r_lo = tlc_pkg::BOUND_SEG4 + 17'd1;
                    r_hi = tlc_pkg::RATIO_MAX;
                end
            endcase
            prod = 33'(full) * 33'($urandom_range(r_lo, r_hi));
            ir   = (prod[32:16] > 17'hFFFF) ? 16'hFFFF : prod[31:16];
        end else if (pick < 85) begin
            full = tlc_pkg::CNT_W'($urandom);
            ir   = tlc_pkg::CNT_W'($urandom);
        end else if (pick < 90) begin
            full = '0;
            ir   = tlc_pkg::CNT_W'($urandom);
        end else begin
            full = tlc_pkg::CNT_W'($urandom_range(1, 15));
            ir   = tlc_pkg::CNT_W'($urandom_range(0, 31));
        end
    endtask

    // Result back-pressure: ready runs and stall runs of random length
    initial begin : result_sink
        bit level;
        int run_left;
        level    = 1'b1;
        run_left = 0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (quiet) begin
                level    = 1'b1;
                run_left = 0;
            end else if (run_left == 0) begin
                level    = ($urandom_range(0, 3) != 0);
                run_left = level ? $urandom_range(1, 12) : pick_gap() + 1;
            end
            if (run_left > 0) run_left--;
            m_axis_tready <= level;
        end
    end

    // Hard stop in case the block hangs
    initial begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        logic [tlc_pkg::RATIO_W-1:0] bounds [4];
        logic [tlc_pkg::CNT_W-1:0]   full;
        logic [tlc_pkg::CNT_W-1:0]   ir;
        int                          b;
        int                          n;
        bounds = '{tlc_pkg::BOUND_SEG1, tlc_pkg::BOUND_SEG2,
                   tlc_pkg::BOUND_SEG3, tlc_pkg::BOUND_SEG4};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero full count, extremes, toggling patterns
        send_pair(16'd0, 16'd0);
        send_pair(16'd0, 16'hFFFF);
        send_pair(16'hFFFF, 16'd0);
        send_pair(16'd1, 16'd0);
        send_pair(16'd1, 16'd1);
        send_pair(16'd1, 16'hFFFF);          // ratio saturates
        send_pair(16'hFFFF, 16'hFFFF);
        send_pair(16'h5555, 16'hAAAA);
        send_pair(16'hAAAA, 16'h5555);
        // directed: just below, exactly on and just above each segment bound
        for (b = 0; b < 4; b++) begin
            full = exact_full(bounds[b]);
            ir   = tlc_pkg::CNT_W'((longint'(bounds[b]) * longint'(full) + 65535) >> 16);
            send_pair(full, ir - 16'd1);
            send_pair(full, ir);
            send_pair(full, ir + 16'd1);
        end
        drain_results();

        // random blocks; the second runs without gaps, a drain after the first
        for (n = 0; n < RANDOM_PAIRS; n++) begin
            if (n == RANDOM_BLOCK) drain_results();
            quiet = (n >= RANDOM_BLOCK && n < 2 * RANDOM_BLOCK);
            make_random_pair(full, ir);
            send_pair(full, ir);
        end
        quiet = 1'b0;
        drain_results();
        repeat (40) @(posedge i_clk);

        $display("Sent %0d count pairs (directed edges, segment bounds, %s).",
                 pairs_sent, "targeted and raw random");
        $display("Checked %0d lux beats; segment codes seen (5..0): %b.", checked, seg_seen);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/tlc_pkg.sv
rtl/core/tlc_div_cell.sv
rtl/core/tlc_seg_path.sv
rtl/core/two_channel_lux_calculator.sv
dv/tlc_lux_checker.sv
dv/two_channel_lux_calculator_tb.sv
